// ===== rtl/qcrm_pkg.sv =====
// ============================================================================
// qcrm_pkg
// Shared types and constants of the quad-SPI controller register model.
// ============================================================================
package qcrm_pkg;

    localparam int REGISTER_COUNT_DEF = 13;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic KIND_SPI  = 1'b0;
    localparam logic KIND_RESP = 1'b1;

    localparam logic [7:0] IX_CR    = 8'd0;
    localparam logic [7:0] IX_SR    = 8'd2;
    localparam logic [7:0] IX_FCR   = 8'd3;
    localparam logic [7:0] IX_DLR   = 8'd4;
    localparam logic [7:0] IX_CCR   = 8'd5;
    localparam logic [7:0] IX_AR    = 8'd6;
    localparam logic [7:0] IX_DR    = 8'd8;
    localparam logic [7:0] IX_PSMKR = 8'd9;
    localparam logic [7:0] IX_PSMAR = 8'd10;

    localparam logic [31:0] MATCH_OR_BIT = 32'h0080_0000;
    localparam logic [31:0] MODE_FIELD   = 32'h0C00_0000;
    localparam logic [31:0] MODE_POLL    = 32'h0800_0000;
    localparam logic [31:0] INSTR_FIELD  = 32'h0000_00FF;
    localparam logic [31:0] ADSIZE_FIELD = 32'h0000_3000;
    localparam logic [31:0] ADMODE_FIELD = 32'h0000_0C00;
    localparam logic [31:0] IMODE_FIELD  = 32'h0000_0300;
    localparam logic [31:0] SR_SMF       = 32'h0000_0008;
    localparam logic [31:0] SR_TCF       = 32'h0000_0002;
    localparam logic [31:0] SR_BSY       = 32'h0000_0020;

    localparam int ADSIZE_LSB = 12;
    localparam logic [2:0] MAX_BYTES = 3'd4;

    localparam logic signed [33:0] COUNT_MAX = {1'b0, {33{1'b1}}};
    localparam logic signed [33:0] COUNT_MIN = {1'b1, 33'b0};

    typedef struct packed {
        logic        func;
        logic [7:0]  reg_index;
        logic [31:0] write_data;
        logic [2:0]  access_size;
        logic [7:0]  flash_reply;
    } t_in_item;

    typedef struct packed {
        logic        item_kind;
        logic [7:0]  spi_byte;
        logic        cs_high;
        logic [31:0] read_data;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic        load;
        logic        step;
        logic [31:0] data;
        logic [2:0]  count;
    } t_tx_ctl;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
        logic       empty;
    } t_tx_sts;

endpackage

// ===== rtl/qcrm_byte_tx.sv =====
// ============================================================================
// qcrm_byte_tx
// Byte serializer: holds a word and hands out its bytes low byte first.
// ============================================================================
module qcrm_byte_tx (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qcrm_pkg::t_tx_ctl i_ctl,
    output qcrm_pkg::t_tx_sts o_sts
);
    import qcrm_pkg::*;

    logic [31:0] r_shift;
    logic [2:0]  r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 3'd0;
        end else if (i_ctl.load) begin
            r_left <= i_ctl.count;
        end else if (i_ctl.step && r_left != 3'd0) begin
            r_left <= r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= i_ctl.data;
        end else if (i_ctl.step) begin
            r_shift <= {8'h00, r_shift[31:8]};
        end
    end

    assign o_sts.tx_byte = r_shift[7:0];
    assign o_sts.last    = (r_left == 3'd1);
    assign o_sts.empty   = (r_left == 3'd0);

endmodule

// ===== rtl/qspi_controller_register_model.sv =====
// ============================================================================
// qspi_controller_register_model
// Register model of a quad-SPI flash controller. Each bus access updates the
// register file and byte count, then returns its SPI bytes and a response.
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+---------------------
//   in      | i_in_valid | o_in_stall  | i_in_item  (t_in_item)
//   out     | o_out_valid| i_out_stall | o_out_item (t_out_item)
//
// A transaction passes through an accept state, an execute state, one send step
// per SPI byte (zero to four) and a response state.
// The byte serializer moves one byte per cycle while the output is not stalled.
// Reset is synchronous, clears registers and count, and sets chip select high.
// Output stalls hold the current item; input is stalled until the response
// has been loaded into the output register.
// ============================================================================
module qspi_controller_register_model #(
    parameter int REGISTER_COUNT = qcrm_pkg::REGISTER_COUNT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qcrm_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qcrm_pkg::t_out_item o_out_item
);
    import qcrm_pkg::*;

    localparam int IDX_W = $clog2(REGISTER_COUNT);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_SEND = 4'b0100,
        S_RESP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_regs [REGISTER_COUNT];
    logic [31:0] n_regs [REGISTER_COUNT];
    logic               r_cs, n_cs;
    logic signed [33:0] r_count, n_count;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;
    t_in_item           r_item;
    logic               r_byte_cs, n_byte_cs;
    logic [31:0]        r_rdata, n_rdata;

    t_tx_ctl tx_ctl;
    t_tx_sts tx_sts;

    logic               out_free;
    logic               known;
    logic [IDX_W-1:0]   ridx;
    logic [2:0]         size;
    logic [2:0]         ad_bytes;
    logic [2:0]         nbytes;
    logic signed [3:0]  delta;
    logic               load_count;
    logic               cs_mid;
    logic [31:0]        masked;
    logic               match;
    logic [31:0]        sr_val;

    function automatic logic signed [33:0] sat_count(input logic signed [33:0] a,
                                                     input logic signed [3:0] d);
        logic signed [34:0] s;
        s = {a[33], a} + {{31{d[3]}}, d};
        if (s[34] != s[33]) begin
            return s[34] ? COUNT_MIN : COUNT_MAX;
        end
        return s[33:0];
    endfunction

    qcrm_byte_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (tx_ctl),
        .o_sts   (tx_sts)
    );

    assign out_free   = !r_out_valid || !i_out_stall;
    assign known      = (r_item.reg_index < 8'(REGISTER_COUNT));
    assign ridx       = r_item.reg_index[IDX_W-1:0];
    assign size       = (r_item.access_size > MAX_BYTES) ? MAX_BYTES : r_item.access_size;
    assign ad_bytes   = 3'({1'b0, r_regs[IX_CCR[IDX_W-1:0]][ADSIZE_LSB +: 2]}) + 3'd1;
    assign masked     = {24'h0, r_item.flash_reply} & r_regs[IX_PSMKR[IDX_W-1:0]];
    assign match      = ((r_regs[IX_CR[IDX_W-1:0]] & MATCH_OR_BIT) == 32'h0)
                        ? (masked == r_regs[IX_PSMAR[IDX_W-1:0]])
                        : ((masked & r_regs[IX_PSMAR[IDX_W-1:0]]) != 32'h0);

    always_comb begin
        n_regs     = r_regs;
        n_cs       = r_cs;
        n_count    = r_count;
        n_byte_cs  = r_byte_cs;
        n_rdata    = r_rdata;
        delta      = 4'sd0;
        load_count = 1'b0;
        nbytes     = 3'd0;
        cs_mid     = r_cs;
        sr_val     = 32'h0;
        tx_ctl     = '0;
        tx_ctl.data = r_item.write_data;

        if (r_state == S_EXEC) begin
            n_byte_cs = r_cs;
            if (r_item.func == FUNC_WRITE) begin
                if (known) begin
                    case (r_item.reg_index)
                        IX_FCR: begin
                            n_regs[IX_SR[IDX_W-1:0]] = r_regs[IX_SR[IDX_W-1:0]]
                                                       & ~r_item.write_data;
                        end
                        IX_CCR: begin
                            if ((r_item.write_data & ADMODE_FIELD) != 32'h0) begin
                                delta = $signed({1'b0,
                                    3'({1'b0, r_item.write_data[ADSIZE_LSB +: 2]}) + 3'd1});
                            end
                            if ((r_item.write_data & MODE_FIELD) != MODE_POLL &&
                                (r_item.write_data & IMODE_FIELD) != 32'h0) begin
                                cs_mid      = 1'b0;
                                n_byte_cs   = 1'b0;
                                nbytes      = 3'd1;
                                tx_ctl.data = r_item.write_data & INSTR_FIELD;
                            end
                            n_regs[ridx] = r_item.write_data;
                        end
                        IX_AR: begin
                            n_regs[ridx] = r_item.write_data;
                            nbytes       = ad_bytes;
                            delta        = 4'sd0 - $signed({1'b0, ad_bytes});
                        end
                        IX_DR: begin
                            n_regs[ridx] = 32'h0;
                            nbytes       = size;
                            delta        = 4'sd0 - $signed({1'b0, size});
                        end
                        IX_DLR: begin
                            n_regs[ridx] = r_item.write_data;
                            load_count   = 1'b1;
                        end
                        default: begin
                            n_regs[ridx] = r_item.write_data;
                        end
                    endcase
                end
                n_count = load_count ? $signed({2'b00, r_item.write_data}) + 34'sd1
                                     : sat_count(r_count, delta);
                n_cs = (n_count <= 34'sd0) ? 1'b1 : cs_mid;
                n_regs[IX_SR[IDX_W-1:0]] = n_regs[IX_SR[IDX_W-1:0]] | SR_TCF;
                n_rdata = 32'h0;
            end else begin
                n_rdata = 32'hFFFF_FFFF;
                if (known) begin
                    case (r_item.reg_index)
                        IX_DR: begin
                            nbytes      = 3'd1;
                            tx_ctl.data = 32'h0;
                            n_rdata     = {24'h0, r_item.flash_reply};
                            delta       = 4'sd0 - $signed({1'b0, size});
                        end
                        IX_SR: begin
                            if ((r_regs[IX_CCR[IDX_W-1:0]] & MODE_FIELD) == MODE_POLL) begin
                                nbytes      = 3'd2;
                                n_byte_cs   = 1'b0;
                                cs_mid      = 1'b1;
                                tx_ctl.data = r_regs[IX_CCR[IDX_W-1:0]] & INSTR_FIELD;
                                if (match) begin
                                    n_regs[IX_SR[IDX_W-1:0]] = r_regs[IX_SR[IDX_W-1:0]]
                                                               | SR_SMF;
                                    n_regs[IX_CCR[IDX_W-1:0]] = r_regs[IX_CCR[IDX_W-1:0]]
                                                                & ~MODE_POLL;
                                end
                            end
                            sr_val  = n_regs[IX_SR[IDX_W-1:0]];
                            n_rdata = sr_val;
                        end
                        default: begin
                            n_rdata = r_regs[ridx];
                        end
                    endcase
                end
                n_count = sat_count(r_count, delta);
                n_cs    = cs_mid;
                if (n_count <= 34'sd0) begin
                    n_cs = 1'b1;
                    n_regs[IX_SR[IDX_W-1:0]] = n_regs[IX_SR[IDX_W-1:0]]
                                               & ~(SR_TCF | SR_BSY);
                end
            end
            tx_ctl.load  = 1'b1;
            tx_ctl.count = nbytes;
        end else if (r_state == S_SEND) begin
            tx_ctl.step = out_free;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = (nbytes != 3'd0) ? S_SEND : S_RESP;
            end
            S_SEND: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.item_kind   = KIND_SPI;
                    n_out.spi_byte    = tx_sts.tx_byte;
                    n_out.cs_high     = r_byte_cs;
                    n_out.read_data   = 32'h0;
                    n_out.last        = 1'b0;
                    if (tx_sts.last) begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.item_kind   = KIND_RESP;
                    n_out.spi_byte    = 8'h00;
                    n_out.cs_high     = r_cs;
                    n_out.read_data   = r_rdata;
                    n_out.last        = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cs        <= 1'b1;
            r_count     <= 34'sd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < REGISTER_COUNT; i++) begin
                r_regs[i] <= 32'h0;
            end
        end else begin
            r_state     <= n_state;
            r_cs        <= n_cs;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_regs      <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_byte_cs <= n_byte_cs;
        r_rdata   <= n_rdata;
        if (r_state == S_IDLE && i_in_valid) begin
            r_item <= i_in_item;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execute");

    a_send_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> !tx_sts.empty)
        else $error("byte state entered with an empty serializer");

    a_write_sets_tcf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_item.func == FUNC_WRITE)
        |=> ((r_regs[IX_SR[IDX_W-1:0]] & SR_TCF) != 32'h0))
        else $error("write transaction left the transfer flag clear");

    a_last_is_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.last) |-> (o_out_item.item_kind == KIND_RESP))
        else $error("last flag on a non-response item");

    a_resp_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && out_free) |=> (r_state == S_IDLE && o_out_item.last))
        else $error("response did not close the transaction");

endmodule
